FILE: design/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg
// Shared types and constants for the JSON pretty printer: character codes,
// the run descriptor handed from the classifier to the emitter, and the
// emitter phase encoding.
// ----------------------------------------------------------------------------
package jpp_pkg;

    localparam int MAX_DEPTH_DEF = 62;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // One output run: [head] [newline] [tabs...] [tail].
    typedef struct packed {
        logic [7:0] head;
        logic       has_head;
        logic       has_lf;
        logic [7:0] tail;
        logic       has_tail;
    } t_run;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_LF,
        PH_TABS,
        PH_TAIL
    } t_phase;

endpackage

FILE: design/jpp_if.sv
// ----------------------------------------------------------------------------
// jpp_if
// Valid/ready channel interfaces for the input text bytes and the indented
// output bytes.
// ----------------------------------------------------------------------------
interface jpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       first_of_text;

    modport source (output valid, output text_byte, output first_of_text, input ready);
    modport sink   (input valid, input text_byte, input first_of_text, output ready);
endinterface

interface jpp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: design/json_pretty_printer.sv
// ----------------------------------------------------------------------------
// json_pretty_printer
// Re-indents compact JSON text with tabs, one input byte per beat.
// ----------------------------------------------------------------------------
// The input channel i_in carries text bytes; first_of_text set on a beat
// clears the nesting depth and string state before that byte is handled.
// The output channel o_out carries the indented text, one byte per beat,
// with last_of_run set on the final beat caused by each input byte.
// Whitespace outside strings is accepted and produces no output beat.
// An input byte is classified in the cycle it is accepted, and its first
// output beat is shown in the next cycle.
// An input byte that yields several output beats holds the output register
// until the final beat of its run is taken, and the next input beat is
// accepted in that cycle, so single-byte runs flow at one beat per cycle
// while ready is high. The longest run is MAX_DEPTH plus two beats.
// When the receiver holds ready low, the current output beat stays on the
// port and the input channel waits until the run's final beat is taken.
// A synchronous active-low reset clears the depth, the string state and the
// output valid flag; no beat is pending after reset.
// ----------------------------------------------------------------------------
module json_pretty_printer #(
    parameter int MAX_DEPTH = jpp_pkg::MAX_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jpp_in_if.sink    i_in,
    jpp_out_if.source o_out
);
    import jpp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);

    t_run          run;
    logic [DW-1:0] tabs;
    logic          drop;
    logic          take;
    logic          fire;

    assign fire       = i_in.valid && take;
    assign i_in.ready = take;

    jpp_classify #(
        .MAX_DEPTH (MAX_DEPTH),
        .DW        (DW)
    ) u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_text_byte     (i_in.text_byte),
        .i_first_of_text (i_in.first_of_text),
        .o_run           (run),
        .o_tabs          (tabs),
        .o_drop          (drop)
    );

    jpp_emitter #(
        .DW (DW)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && !drop),
        .i_run       (run),
        .i_tabs      (tabs),
        .i_out_ready (o_out.ready),
        .o_take      (take),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_last      (o_out.last_of_run)
    );

endmodule

FILE: design/jpp_classify.sv
// ----------------------------------------------------------------------------
// jpp_classify
// Holds the nesting depth and string state, and turns each accepted input
// byte into a run descriptor for the emitter.
// ----------------------------------------------------------------------------
module jpp_classify #(
    parameter int MAX_DEPTH = jpp_pkg::MAX_DEPTH_DEF,
    parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_text_byte,
    input  logic           i_first_of_text,
    output jpp_pkg::t_run  o_run,
    output logic [DW-1:0]  o_tabs,
    output logic           o_drop
);
    import jpp_pkg::*;

    localparam logic [DW-1:0] DEPTH_TOP = DW'(MAX_DEPTH);

    logic [DW-1:0] r_depth, n_depth;
    logic          r_in_str, n_in_str;
    logic          r_esc, n_esc;

    logic [DW-1:0] cur_depth;
    logic          cur_in_str;
    logic          cur_esc;

    always_comb begin
        cur_depth  = i_first_of_text ? '0   : r_depth;
        cur_in_str = i_first_of_text ? 1'b0 : r_in_str;
        cur_esc    = i_first_of_text ? 1'b0 : r_esc;

        n_depth  = cur_depth;
        n_in_str = cur_in_str;
        n_esc    = cur_esc;

        o_run.head     = i_text_byte;
        o_run.has_head = 1'b1;
        o_run.has_lf   = 1'b0;
        o_run.tail     = i_text_byte;
        o_run.has_tail = 1'b0;
        o_tabs         = '0;
        o_drop         = 1'b0;

        if (cur_in_str) begin
            if (cur_esc) begin
                n_esc = 1'b0;
            end else if (i_text_byte == CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (i_text_byte == CH_QUOTE) begin
                n_in_str = 1'b0;
            end
        end else begin
            case (i_text_byte)
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                    o_drop = 1'b1;
                end
                CH_LBRACE, CH_LBRACK: begin
                    if (cur_depth < DEPTH_TOP) begin
                        n_depth = cur_depth + 1'b1;
                    end
                    o_run.has_lf = 1'b1;
                    o_tabs       = n_depth;
                end
                CH_RBRACE, CH_RBRACK: begin
                    if (cur_depth != '0) begin
                        n_depth = cur_depth - 1'b1;
                    end
                    o_run.has_head = 1'b0;
                    o_run.has_lf   = 1'b1;
                    o_run.has_tail = 1'b1;
                    o_tabs         = n_depth;
                end
                CH_COLON: begin
                    o_run.tail     = CH_SPACE;
                    o_run.has_tail = 1'b1;
                end
                CH_COMMA: begin
                    o_run.has_lf = 1'b1;
                    o_tabs       = cur_depth;
                end
                CH_QUOTE: begin
                    n_in_str = 1'b1;
                    n_esc    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
        end else if (i_fire) begin
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
        end
    end

endmodule

FILE: design/jpp_emitter.sv
// ----------------------------------------------------------------------------
// jpp_emitter
// Holds one run descriptor and plays it out as output beats, one byte per
// cycle while the receiver is ready, marking the final beat of the run.
// ----------------------------------------------------------------------------
module jpp_emitter #(
    parameter int DW = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  jpp_pkg::t_run  i_run,
    input  logic [DW-1:0]  i_tabs,
    input  logic           i_out_ready,
    output logic           o_take,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);
    import jpp_pkg::*;

    logic          r_valid, n_valid;
    t_phase        r_phase, n_phase;
    t_run          r_run, n_run;
    logic [DW-1:0] r_tabs, n_tabs;

    t_phase        adv_phase;
    t_phase        start_phase;
    logic          out_fire;

    always_comb begin
        case (r_phase)
            PH_HEAD: begin
                if (r_run.has_lf) begin
                    adv_phase = PH_LF;
                end else if (r_tabs != '0) begin
                    adv_phase = PH_TABS;
                end else begin
                    adv_phase = PH_TAIL;
                end
            end
            PH_LF: begin
                adv_phase = (r_tabs != '0) ? PH_TABS : PH_TAIL;
            end
            PH_TABS: begin
                adv_phase = (r_tabs != DW'(1)) ? PH_TABS : PH_TAIL;
            end
            default: begin
                adv_phase = PH_TAIL;
            end
        endcase

        if (i_run.has_head) begin
            start_phase = PH_HEAD;
        end else if (i_run.has_lf) begin
            start_phase = PH_LF;
        end else begin
            start_phase = PH_TAIL;
        end
    end

    always_comb begin
        case (r_phase)
            PH_HEAD: o_out_byte = r_run.head;
            PH_LF:   o_out_byte = CH_LF;
            PH_TABS: o_out_byte = CH_TAB;
            PH_TAIL: o_out_byte = r_run.tail;
            default: o_out_byte = r_run.tail;
        endcase
        o_last      = (r_phase == PH_TAIL) || (adv_phase == PH_TAIL && !r_run.has_tail);
        o_out_valid = r_valid;
        out_fire    = r_valid && i_out_ready;
        o_take      = !r_valid || (i_out_ready && o_last);
    end

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_run   = r_run;
        n_tabs  = r_tabs;
        if (i_load) begin
            n_valid = 1'b1;
            n_phase = start_phase;
            n_run   = i_run;
            n_tabs  = i_tabs;
        end else if (out_fire) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_phase = adv_phase;
                if (r_phase == PH_TABS) begin
                    n_tabs = r_tabs - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_HEAD;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run  <= n_run;
        r_tabs <= n_tabs;
    end

endmodule

FILE: design/jpp_checker.sv
// ----------------------------------------------------------------------------
// jpp_checker
// Port-level checks for the JSON pretty printer, bound to the top level.
// ----------------------------------------------------------------------------
module jpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last))
        else $error("Stalled output beat changed.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output beat pending after reset.");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("Input taken in the middle of an output run.");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last && !(i_in_valid && i_in_ready)
            |=> !i_out_valid)
        else $error("Output beat appeared without an input beat.");

endmodule

bind json_pretty_printer jpp_checker u_jpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run)
);
